// ===== src/assert_macros.svh =====
// assertion macros shared by the quaternion unit rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// clocked check, switched off while reset is high
`define QAU_ASSERT_CLK(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// clocked check that holds through reset as well
`define QAU_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define QAU_ASSERT_CLK(name, clk, rst, prop, msg)
`define QAU_ASSERT_ALWAYS(name, clk, prop, msg)
`endif
`endif

// ===== src/qau_pkg.sv =====
// types and constants of the quaternion arithmetic unit
`default_nettype none
package qau_pkg;

   localparam int COMP_W    = 32;
   localparam int NUM_LANES = 16;

   // operation codes
   typedef enum logic [2:0] {
      FUNC_MUL      = 3'd0,
      FUNC_ADD      = 3'd1,
      FUNC_CONJ_MUL = 3'd2,
      FUNC_ROTATE   = 3'd3,
      FUNC_CONJ     = 3'd4,
      FUNC_SCALE    = 3'd5
   } func_type;

   typedef logic signed [COMP_W-1:0] comp_type;

   localparam comp_type COMP_MAX = 32'sh7fff_ffff;
   localparam comp_type COMP_MIN = 32'sh8000_0000;

   // request word
   typedef struct packed {
      logic [2:0] func;
      comp_type   a_x;
      comp_type   a_y;
      comp_type   a_z;
      comp_type   a_w;
      comp_type   b_x;
      comp_type   b_y;
      comp_type   b_z;
      comp_type   b_w;
   } req_type;

   // response word
   typedef struct packed {
      comp_type r_x;
      comp_type r_y;
      comp_type r_z;
      comp_type r_w;
      logic     overflow;
   } rsp_type;

endpackage
`default_nettype wire

// ===== src/qau_rmul.sv =====
// signed multiplier with round to nearest (ties up) and a fixed right shift
`default_nettype none
module qau_rmul #(
   parameter int A_W   = 33,
   parameter int B_W   = 32,
   parameter int SHIFT = 16,
   parameter int OUT_W = 50
) (
   input  logic signed [A_W-1:0]   a,
   input  logic signed [B_W-1:0]   b,
   output logic signed [OUT_W-1:0] p
);
   localparam int PROD_W = A_W + B_W;
   localparam logic signed [PROD_W-1:0] HALF = PROD_W'(1) <<< (SHIFT - 1);

   logic signed [PROD_W-1:0] prod;
   logic signed [PROD_W-1:0] biased;
   logic signed [PROD_W-1:0] shifted;

   // full product, add half an lsb, floor shift
   assign prod    = PROD_W'(a) * PROD_W'(b);
   assign biased  = prod + HALF;
   assign shifted = biased >>> SHIFT;
   assign p       = shifted[OUT_W-1:0];

endmodule
`default_nettype wire

// ===== src/qau_mul_stage.sv =====
// first product stage: sixteen rounded products of A (or conj A) and B
`default_nettype none
module qau_mul_stage #(
   parameter int FRAC_BITS = 16,
   parameter int PROD_W    = 50
) (
   input  logic                    clock,
   input  logic                    load,
   input  qau_pkg::req_type        data_i,
   output qau_pkg::req_type        data_ff,
   output logic signed [PROD_W-1:0] prod_ff [qau_pkg::NUM_LANES]
);
   import qau_pkg::*;

   localparam int OPA_W = COMP_W + 1;

   // lane k multiplies lhs[LANE_L[k]] by rhs[LANE_R[k]], components x y z w
   // lanes 4c..4c+3 feed result component c of the hamilton product
   localparam logic [1:0] LANE_L [NUM_LANES] = '{
      2'd3, 2'd0, 2'd1, 2'd2,
      2'd3, 2'd1, 2'd2, 2'd0,
      2'd3, 2'd2, 2'd0, 2'd1,
      2'd3, 2'd0, 2'd1, 2'd2
   };
   localparam logic [1:0] LANE_R [NUM_LANES] = '{
      2'd0, 2'd3, 2'd2, 2'd1,
      2'd1, 2'd3, 2'd0, 2'd2,
      2'd2, 2'd3, 2'd1, 2'd0,
      2'd3, 2'd0, 2'd1, 2'd2
   };

   logic signed [OPA_W-1:0]  lhs [4];
   comp_type                 rhs [4];
   logic signed [PROD_W-1:0] prod_in [NUM_LANES];
   logic                     neg_xyz;

   // conj A negates the vector part exactly, one bit wider
   assign neg_xyz = (data_i.func == FUNC_CONJ_MUL);

   always_comb begin
      lhs[0] = neg_xyz ? -OPA_W'(data_i.a_x) : OPA_W'(data_i.a_x);
      lhs[1] = neg_xyz ? -OPA_W'(data_i.a_y) : OPA_W'(data_i.a_y);
      lhs[2] = neg_xyz ? -OPA_W'(data_i.a_z) : OPA_W'(data_i.a_z);
      lhs[3] = OPA_W'(data_i.a_w);
      rhs[0] = data_i.b_x;
      rhs[1] = data_i.b_y;
      rhs[2] = data_i.b_z;
      rhs[3] = data_i.b_w;
   end

   // multiplier lanes
   for (genvar k = 0; k < NUM_LANES; k++) begin : g_lane
      qau_rmul #(
         .A_W   (OPA_W),
         .B_W   (COMP_W),
         .SHIFT (FRAC_BITS),
         .OUT_W (PROD_W)
      ) u_rmul (
         .a (lhs[LANE_L[k]]),
         .b (rhs[LANE_R[k]]),
         .p (prod_in[k])
      );
   end

   // stage register
   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data_i;
         prod_ff <= prod_in;
      end
   end

endmodule
`default_nettype wire

// ===== src/qau_sum_stage.sv =====
// second stage: product sums per operation, saturated cross product for rotation
`default_nettype none
module qau_sum_stage #(
   parameter int PROD_W = 50,
   parameter int SUM_W  = 53
) (
   input  logic                     clock,
   input  logic                     load,
   input  qau_pkg::req_type         data_i,
   input  logic signed [PROD_W-1:0] prod_i [qau_pkg::NUM_LANES],
   output qau_pkg::req_type         data_ff,
   output logic signed [SUM_W-1:0]  sum_ff [4],
   output qau_pkg::comp_type        uv_ff [3],
   output logic                     uv_ovf_ff
);
   import qau_pkg::*;

   localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(COMP_MAX);
   localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(COMP_MIN);

   logic signed [SUM_W-1:0] sum_in [4];
   logic signed [SUM_W-1:0] p [NUM_LANES];
   comp_type                uv_in [3];
   logic                    uv_ovf_in;
   logic [2:0]              uv_hit;

   always_comb begin
      for (int k = 0; k < NUM_LANES; k++) begin
         p[k] = SUM_W'(prod_i[k]);
      end
   end

   // per operation sums of the products
   always_comb begin
      for (int c = 0; c < 4; c++) begin
         sum_in[c] = '0;
      end
      unique case (data_i.func)
         FUNC_MUL, FUNC_CONJ_MUL: begin
            for (int c = 0; c < 3; c++) begin
               sum_in[c] = p[4*c] + p[4*c+1] + p[4*c+2] - p[4*c+3];
            end
            sum_in[3] = p[12] - p[13] - p[14] - p[15];
         end
         FUNC_ADD: begin
            sum_in[0] = SUM_W'(data_i.a_x) + SUM_W'(data_i.b_x);
            sum_in[1] = SUM_W'(data_i.a_y) + SUM_W'(data_i.b_y);
            sum_in[2] = SUM_W'(data_i.a_z) + SUM_W'(data_i.b_z);
            sum_in[3] = SUM_W'(data_i.a_w) + SUM_W'(data_i.b_w);
         end
         FUNC_ROTATE: begin
            // the cross-product lanes of the hamilton product give A.xyz x B.xyz
            for (int c = 0; c < 3; c++) begin
               sum_in[c] = p[4*c+2] - p[4*c+3];
            end
         end
         FUNC_CONJ: begin
            sum_in[0] = -SUM_W'(data_i.a_x);
            sum_in[1] = -SUM_W'(data_i.a_y);
            sum_in[2] = -SUM_W'(data_i.a_z);
            sum_in[3] = SUM_W'(data_i.a_w);
         end
         FUNC_SCALE: begin
            for (int c = 0; c < 3; c++) begin
               sum_in[c] = p[4*c+1];
            end
            sum_in[3] = p[12];
         end
         default: begin
            for (int c = 0; c < 4; c++) begin
               sum_in[c] = '0;
            end
         end
      endcase
   end

   // saturate the cross product used by the second rotation round
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         uv_hit[c] = 1'b0;
         if (sum_in[c] > SAT_HI) begin
            uv_in[c]  = COMP_MAX;
            uv_hit[c] = 1'b1;
         end else if (sum_in[c] < SAT_LO) begin
            uv_in[c]  = COMP_MIN;
            uv_hit[c] = 1'b1;
         end else begin
            uv_in[c] = sum_in[c][COMP_W-1:0];
         end
      end
      uv_ovf_in = (data_i.func == FUNC_ROTATE) && (uv_hit != 3'b000);
   end

   // stage register
   always_ff @(posedge clock) begin
      if (load) begin
         data_ff   <= data_i;
         sum_ff    <= sum_in;
         uv_ff     <= uv_in;
         uv_ovf_ff <= uv_ovf_in;
      end
   end

endmodule
`default_nettype wire

// ===== src/qau_rot_stage.sv =====
// third stage: second rotation product round, A.xyz x uv and uv scaled by 2*A.w
`default_nettype none
module qau_rot_stage #(
   parameter int FRAC_BITS = 16,
   parameter int PROD_W    = 50,
   parameter int SUM_W     = 53
) (
   input  logic                     clock,
   input  logic                     load,
   input  qau_pkg::req_type         data_i,
   input  logic signed [SUM_W-1:0]  sum_i [4],
   input  qau_pkg::comp_type        uv_i [3],
   input  logic                     uv_ovf_i,
   output qau_pkg::req_type         data_ff,
   output logic signed [SUM_W-1:0]  sum_ff [4],
   output logic                     uv_ovf_ff,
   output logic signed [PROD_W-1:0] cross_ff [6],
   output logic signed [PROD_W-1:0] scl_ff [3]
);
   import qau_pkg::*;

   // cross lane pairs: component c is lane 2c minus lane 2c+1
   localparam logic [1:0] A_IDX  [6] = '{2'd1, 2'd2, 2'd2, 2'd0, 2'd0, 2'd1};
   localparam logic [1:0] UV_IDX [6] = '{2'd2, 2'd1, 2'd0, 2'd2, 2'd1, 2'd0};

   comp_type                 a_vec [3];
   logic signed [PROD_W-1:0] cross_in [6];
   logic signed [PROD_W-1:0] scl_in [3];

   assign a_vec[0] = data_i.a_x;
   assign a_vec[1] = data_i.a_y;
   assign a_vec[2] = data_i.a_z;

   // A.xyz x uv, rounded at the working format
   for (genvar k = 0; k < 6; k++) begin : g_cross
      qau_rmul #(
         .A_W   (COMP_W),
         .B_W   (COMP_W),
         .SHIFT (FRAC_BITS),
         .OUT_W (PROD_W)
      ) u_rmul (
         .a (a_vec[A_IDX[k]]),
         .b (uv_i[UV_IDX[k]]),
         .p (cross_in[k])
      );
   end

   // uv * 2 * A.w, one bit less of shift
   for (genvar c = 0; c < 3; c++) begin : g_scale
      qau_rmul #(
         .A_W   (COMP_W),
         .B_W   (COMP_W),
         .SHIFT (FRAC_BITS - 1),
         .OUT_W (PROD_W)
      ) u_rmul (
         .a (uv_i[c]),
         .b (data_i.a_w),
         .p (scl_in[c])
      );
   end

   // stage register
   always_ff @(posedge clock) begin
      if (load) begin
         data_ff   <= data_i;
         sum_ff    <= sum_i;
         uv_ovf_ff <= uv_ovf_i;
         cross_ff  <= cross_in;
         scl_ff    <= scl_in;
      end
   end

endmodule
`default_nettype wire

// ===== src/quaternion_arithmetic_unit.sv =====
// top level of the pipelined quaternion arithmetic unit
//
// Usage: a request word on req_data (func, quaternions A and B) is taken at
// a clock edge where req_valid and req_ready are both high; one response word
// (r_x, r_y, r_z, r_w, overflow) per request leaves on rsp_data, taken when
// rsp_valid and rsp_ready are both high. Responses keep request order.
// Components are signed fixed point with FRAC_BITS fractional bits.
// Each accepted word passes the four register stages (first products, sums,
// second rotation products, final sum and saturation into the output register)
// before rsp_valid. Throughput: one word per cycle while rsp_ready is high.
// Every operation takes the same path; codes 6 and 7 return all zero.
// Stalls: each stage holds its word while the next one is full and blocked;
// empty stages still fill, so req_ready falls only once all four stages hold
// a word and rsp_ready is low. Nothing is dropped or repeated.
// Reset (synchronous, active high) empties every stage; rsp_valid falls in
// the next cycle and req_ready is high until the stages fill again.
`default_nettype none
`include "assert_macros.svh"
module quaternion_arithmetic_unit #(
   parameter int FRAC_BITS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  qau_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output qau_pkg::rsp_type rsp_data
);
   import qau_pkg::*;

   localparam int PROD_W = 66 - FRAC_BITS;
   localparam int SUM_W  = PROD_W + 3;
   localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(COMP_MAX);
   localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(COMP_MIN);

   // stage valid bits
   logic v1_ff, v2_ff, v3_ff, out_valid_ff;
   logic v1_in, v2_in, v3_in, out_valid_in;
   logic rdy1, rdy2, rdy3, rdy4;
   logic [3:0] occ_vec;

   // stage data
   req_type                  s1_data, s2_data, s3_data;
   logic signed [PROD_W-1:0] s1_prod [NUM_LANES];
   logic signed [SUM_W-1:0]  s2_sum [4];
   comp_type                 s2_uv [3];
   logic                     s2_uv_ovf;
   logic signed [SUM_W-1:0]  s3_sum [4];
   logic                     s3_uv_ovf;
   logic signed [PROD_W-1:0] s3_cross [6];
   logic signed [PROD_W-1:0] s3_scl [3];

   // final stage
   comp_type                b_vec [3];
   logic signed [SUM_W-1:0] fin [4];
   comp_type                res [4];
   logic [3:0]              hit;
   rsp_type                 rsp_in, rsp_ff;

   // ready chain: a stage loads when empty or when its word moves on
   assign rdy4 = !out_valid_ff || rsp_ready;
   assign rdy3 = !v3_ff || rdy4;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;

   assign v1_in        = rdy1 ? req_valid : v1_ff;
   assign v2_in        = rdy2 ? v1_ff : v2_ff;
   assign v3_in        = rdy3 ? v2_ff : v3_ff;
   assign out_valid_in = rdy4 ? v3_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         v1_ff        <= v1_in;
         v2_ff        <= v2_in;
         v3_ff        <= v3_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign req_ready = rdy1;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = rsp_ff;
   assign occ_vec   = {v1_ff, v2_ff, v3_ff, out_valid_ff};

   // first products
   qau_mul_stage #(
      .FRAC_BITS (FRAC_BITS),
      .PROD_W    (PROD_W)
   ) u_mul_stage (
      .clock   (clock),
      .load    (rdy1),
      .data_i  (req_data),
      .data_ff (s1_data),
      .prod_ff (s1_prod)
   );

   // sums
   qau_sum_stage #(
      .PROD_W (PROD_W),
      .SUM_W  (SUM_W)
   ) u_sum_stage (
      .clock     (clock),
      .load      (rdy2),
      .data_i    (s1_data),
      .prod_i    (s1_prod),
      .data_ff   (s2_data),
      .sum_ff    (s2_sum),
      .uv_ff     (s2_uv),
      .uv_ovf_ff (s2_uv_ovf)
   );

   // second rotation products
   qau_rot_stage #(
      .FRAC_BITS (FRAC_BITS),
      .PROD_W    (PROD_W),
      .SUM_W     (SUM_W)
   ) u_rot_stage (
      .clock     (clock),
      .load      (rdy3),
      .data_i    (s2_data),
      .sum_i     (s2_sum),
      .uv_i      (s2_uv),
      .uv_ovf_i  (s2_uv_ovf),
      .data_ff   (s3_data),
      .sum_ff    (s3_sum),
      .uv_ovf_ff (s3_uv_ovf),
      .cross_ff  (s3_cross),
      .scl_ff    (s3_scl)
   );

   assign b_vec[0] = s3_data.b_x;
   assign b_vec[1] = s3_data.b_y;
   assign b_vec[2] = s3_data.b_z;

   // final sum: v + round(2w uv) + 2 uuv for rotation, otherwise the stage sums
   always_comb begin
      if (s3_data.func == FUNC_ROTATE) begin
         for (int c = 0; c < 3; c++) begin
            fin[c] = SUM_W'(b_vec[c]) + SUM_W'(s3_scl[c])
                   + ((SUM_W'(s3_cross[2*c]) - SUM_W'(s3_cross[2*c+1])) <<< 1);
         end
         fin[3] = '0;
      end else begin
         for (int c = 0; c < 4; c++) begin
            fin[c] = s3_sum[c];
         end
      end
   end

   // saturation of each component
   always_comb begin
      for (int c = 0; c < 4; c++) begin
         hit[c] = 1'b0;
         if (fin[c] > SAT_HI) begin
            res[c] = COMP_MAX;
            hit[c] = 1'b1;
         end else if (fin[c] < SAT_LO) begin
            res[c] = COMP_MIN;
            hit[c] = 1'b1;
         end else begin
            res[c] = fin[c][COMP_W-1:0];
         end
      end
      rsp_in.r_x      = res[0];
      rsp_in.r_y      = res[1];
      rsp_in.r_z      = res[2];
      rsp_in.r_w      = res[3];
      rsp_in.overflow = (hit != 4'b0000) || s3_uv_ovf;
   end

   // output register
   always_ff @(posedge clock) begin
      if (rdy4) begin
         rsp_ff <= rsp_in;
      end
   end

   // the input stalls only when every stage is full and the output is blocked
   `QAU_ASSERT_CLK(a_ready_chain, clock, reset,
      req_ready == (!v1_ff || !v2_ff || !v3_ff || !out_valid_ff || rsp_ready),
      "ready does not follow pipeline occupancy")
   // a word taken in and none delivered adds one to the occupancy
   `QAU_ASSERT_CLK(a_occ_up, clock, reset,
      (req_valid && req_ready && !(rsp_valid && rsp_ready))
         |=> ($countones(occ_vec) == $past($countones(occ_vec)) + 1),
      "word lost in pipeline")
   // a word delivered and none taken in removes one
   `QAU_ASSERT_CLK(a_occ_down, clock, reset,
      (rsp_valid && rsp_ready && !(req_valid && req_ready))
         |=> ($countones(occ_vec) == $past($countones(occ_vec)) - 1),
      "word repeated in pipeline")
   // an idle input cycle leaves a bubble in the first stage
   `QAU_ASSERT_CLK(a_bubble, clock, reset, (req_ready && !req_valid) |=> !v1_ff,
      "first stage valid without a request")

endmodule
`default_nettype wire
